// ===== hdl/rgb_frame_gamma_dimmer_macros.svh =====
// assertion macros for the frame receiver checks
`ifndef RGB_FRAME_GAMMA_DIMMER_MACROS_SVH
`define RGB_FRAME_GAMMA_DIMMER_MACROS_SVH

// consequent in the next cycle, off while in reset
`define RFGD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfgd check failed");

// consequent in the same cycle, off while in reset
`define RFGD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfgd check failed");

// checked through reset as well
`define RFGD_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rfgd check failed");

`endif

// ===== hdl/rfgd_pkg.sv =====
package rfgd_pkg;

  localparam int BYTE_W  = 8;
  localparam int CHAN_W  = 6;
  localparam int LEVEL_W = 12;
  localparam int PCT_W   = 7;
  localparam int OP_W    = 13;
  localparam int PROD_W  = OP_W + LEVEL_W;
  localparam int QDEPTH  = 4;

  localparam logic [BYTE_W-1:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 12'd4095;

  // configuration register indexes
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_GAMMA      = 1'b1;

  // byte order within a strip triple
  typedef enum logic [1:0] {
    COL_RED   = 2'd0,
    COL_GREEN = 2'd1,
    COL_BLUE  = 2'd2
  } colour_t;

  // driver channel offsets within a strip
  localparam logic [CHAN_W-1:0] CH_GREEN = 6'd0;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 6'd1;
  localparam logic [CHAN_W-1:0] CH_RED   = 6'd2;
  localparam logic [CHAN_W-1:0] CH_STEP  = 6'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [BYTE_W-1:0] data;
    logic              last;
  } q_item_t;

  // floor(min(p,100) * 4095 / 100) as 40*pc + floor(95*pc / 100)
  function automatic logic [LEVEL_W-1:0] level_limit(input logic [PCT_W-1:0] p);
    logic [PCT_W-1:0] pc;
    logic [13:0]      m;
    logic [27:0]      q;
    logic [12:0]      l;
    pc = (p > PCT_MAX) ? PCT_MAX : p;
    m  = ({7'd0, pc} << 6) + ({7'd0, pc} << 5) - {7'd0, pc};
    q  = {14'd0, m} * 28'd10486;
    l  = ({6'd0, pc} << 5) + ({6'd0, pc} << 3) + {5'd0, q[27:20]};
    return l[LEVEL_W-1:0];
  endfunction

  // floor(p / 255) for p below 2^20, by folding base-256 digits
  function automatic logic [LEVEL_W-1:0] div255(input logic [19:0] p);
    logic [12:0] s;
    logic [8:0]  t;
    logic [12:0] q;
    s = {1'b0, p[19:8]} + {5'd0, p[7:0]};
    t = {4'd0, s[12:8]} + {1'b0, s[7:0]};
    q = {1'b0, p[19:8]} + {8'd0, s[12:8]} + {12'd0, (t >= 9'd255)};
    return q[LEVEL_W-1:0];
  endfunction

endpackage

// ===== hdl/rfgd_if.sv =====
interface rfgd_in_if;
  import rfgd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfgd_out_if;
  import rfgd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  channel_index;
  logic [LEVEL_W-1:0] drive_level;
  logic               frame_end;
  modport source (output valid, output channel_index, output drive_level,
                  output frame_end, input ready);
  modport sink (input valid, input channel_index, input drive_level,
                input frame_end, output ready);
endinterface

// ===== hdl/rfgd_parser.sv =====
module rfgd_parser #(
  parameter int STRIPS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rfgd_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                      q_full,
  output logic                      q_push,
  output rfgd_pkg::q_item_t         q_item
);
  import rfgd_pkg::*;

  localparam int FRAME_LEN = 3 * STRIPS;
  localparam int PW        = $clog2(FRAME_LEN);

  logic              in_frame_r;
  logic [PW-1:0]     pos_r;
  colour_t           colour_r;
  logic [CHAN_W-1:0] base_r;
  logic              accept;
  logic              last;
  logic [CHAN_W-1:0] offset;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign last     = (pos_r == PW'(FRAME_LEN - 1));

  always_comb begin
    unique case (colour_r)
      COL_RED:   offset = CH_RED;
      COL_GREEN: offset = CH_GREEN;
      COL_BLUE:  offset = CH_BLUE;
      default:   offset = CH_RED;
    endcase
  end

  assign q_push      = accept && in_frame_r;
  assign q_item.chan = base_r + offset;
  assign q_item.data = in_rx_byte;
  assign q_item.last = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      colour_r   <= COL_RED;
      base_r     <= '0;
    end else if (accept) begin
      if (!in_frame_r) begin
        if (in_rx_byte == SYNC_BYTE) begin
          in_frame_r <= 1'b1;
          pos_r      <= '0;
          colour_r   <= COL_RED;
          base_r     <= '0;
        end
      end else if (last) begin
        in_frame_r <= 1'b0;
        pos_r      <= '0;
      end else begin
        pos_r <= pos_r + PW'(1);
        unique case (colour_r)
          COL_RED:   colour_r <= COL_GREEN;
          COL_GREEN: colour_r <= COL_BLUE;
          COL_BLUE: begin
            colour_r <= COL_RED;
            base_r   <= base_r + CH_STEP;
          end
          default:   colour_r <= COL_RED;
        endcase
      end
    end
  end

endmodule

// ===== hdl/rfgd_queue.sv =====
module rfgd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rfgd_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rfgd_pkg::q_item_t pop_item
);
  import rfgd_pkg::*;

  localparam int AW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  q_item_t       slot_r [QDEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == CW'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/rfgd_scaler.sv =====
module rfgd_scaler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [rfgd_pkg::PCT_W-1:0]   cfg_data,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  rfgd_pkg::q_item_t            q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rfgd_pkg::CHAN_W-1:0]  out_channel_index,
  output logic [rfgd_pkg::LEVEL_W-1:0] out_drive_level,
  output logic                         out_frame_end
);
  import rfgd_pkg::*;

  logic [LEVEL_W-1:0] lim_r;
  logic               gamma_r;

  logic               s1_vld_r;
  logic [OP_W-1:0]    s1_op_r;
  logic               s1_gam_r;
  logic [CHAN_W-1:0]  s1_chan_r;
  logic               s1_last_r;

  logic               s2_vld_r;
  logic [PROD_W-1:0]  s2_prod_r;
  logic               s2_gam_r;
  logic [CHAN_W-1:0]  s2_chan_r;
  logic               s2_last_r;

  logic               out_vld_r;
  logic [CHAN_W-1:0]  out_chan_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_last_r;

  logic               adv;
  logic [8:0]         x1;
  logic [17:0]        sq;
  logic [OP_W-1:0]    op;
  logic [LEVEL_W-1:0] level;

  // whole pipe moves together, held while the output register waits
  assign adv   = !out_vld_r || out_ready;
  assign q_pop = adv && !q_empty;

  assign x1    = {1'b0, q_item.data} + 9'd1;
  assign sq    = {9'd0, x1} * {9'd0, x1};
  assign op    = gamma_r ? sq[16:4] : {5'd0, q_item.data};
  assign level = s2_gam_r ? s2_prod_r[23:12] : div255(s2_prod_r[19:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r   <= FULL_LEVEL;
      gamma_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BRIGHTNESS: lim_r   <= level_limit(cfg_data);
        REG_GAMMA:      gamma_r <= cfg_data[0];
        default:        lim_r   <= lim_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= !q_empty;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r     <= op;
      s1_gam_r    <= gamma_r;
      s1_chan_r   <= q_item.chan;
      s1_last_r   <= q_item.last;
      s2_prod_r   <= {{LEVEL_W{1'b0}}, s1_op_r} * {{OP_W{1'b0}}, lim_r};
      s2_gam_r    <= s1_gam_r;
      s2_chan_r   <= s1_chan_r;
      s2_last_r   <= s1_last_r;
      out_chan_r  <= s2_chan_r;
      out_level_r <= level;
      out_last_r  <= s2_last_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_channel_index = out_chan_r;
  assign out_drive_level   = out_level_r;
  assign out_frame_end     = out_last_r;

endmodule

// ===== hdl/rgb_frame_gamma_dimmer.sv =====
// one byte accepted per cycle while the four-entry queue has room
// a colour byte gives its channel result after passing in order through
// the queue read, squaring stage, brightness multiply and output register
// sync and dropped bytes give no result and only move the frame parser
// synchronous active-low reset: waiting for sync, queue and pipe empty,
// brightness 100 percent, gamma curve on
module rgb_frame_gamma_dimmer #(
  parameter int STRIPS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [rfgd_pkg::PCT_W-1:0] cfg_data,
  rfgd_in_if.sink                    in_ch,
  rfgd_out_if.source                 out_ch
);
  import rfgd_pkg::*;

  logic    q_full;
  logic    q_empty;
  logic    q_push;
  logic    q_pop;
  q_item_t push_item;
  q_item_t pop_item;

  rfgd_parser #(
    .STRIPS(STRIPS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_rx_byte(in_ch.rx_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  rfgd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_item (pop_item)
  );

  rfgd_scaler u_scaler (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_item           (pop_item),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_channel_index(out_ch.channel_index),
    .out_drive_level  (out_ch.drive_level),
    .out_frame_end    (out_ch.frame_end)
  );

endmodule

// ===== hdl/rfgd_checker.sv =====
`include "rgb_frame_gamma_dimmer_macros.svh"

module rfgd_checker #(
  parameter int STRIPS = 20
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rfgd_pkg::CHAN_W-1:0]  out_channel_index,
  input logic [rfgd_pkg::LEVEL_W-1:0] out_drive_level,
  input logic                         out_frame_end
);
  import rfgd_pkg::*;

  localparam int LAST_CHAN_FULL = 3 * (STRIPS - 1) + 1;
  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(LAST_CHAN_FULL % 64);

  `RFGD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RFGD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                    $stable({out_channel_index, out_drive_level, out_frame_end}))
  `RFGD_ASSERT_NOW(a_frame_end_chan, out_valid && out_frame_end,
                   out_channel_index == LAST_CHAN)
  `RFGD_ASSERT_RESET(a_reset_quiet, !rst_n, !out_valid)

endmodule

bind rgb_frame_gamma_dimmer rfgd_checker #(
  .STRIPS(STRIPS)
) u_rfgd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_channel_index(out_ch.channel_index),
  .out_drive_level  (out_ch.drive_level),
  .out_frame_end    (out_ch.frame_end)
);

// ===== tb/sv/rfgd_frame_checker.sv =====
module rfgd_frame_checker #(
  parameter int STRIPS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [rfgd_pkg::PCT_W-1:0] cfg_data,
  rfgd_in_if                         in_mon,
  rfgd_out_if                        out_mon,
  output int                         failures,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rfgd_pkg::*;

  typedef struct {
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } channel_result_t;

  channel_result_t  due_q[$];
  logic [PCT_W-1:0] brightness;
  logic             gamma_on;
  logic             framing;
  int unsigned      byte_pos;

  function automatic logic [LEVEL_W-1:0] graded_level(input logic [BYTE_W-1:0] x,
                                                     input logic [PCT_W-1:0] pct,
                                                     input logic gamma);
    int unsigned pc;
    int unsigned lim;
    int unsigned sq;
    int unsigned v;
    pc  = (pct > PCT_MAX) ? 32'(PCT_MAX) : 32'(pct);
    lim = (pc * 32'(FULL_LEVEL)) / 100;
    if (gamma) begin
      sq = ((32'(x) + 1) * (32'(x) + 1)) >> 4;
      v  = (sq * lim) / 4096;
    end else begin
      v = (32'(x) * lim) / 255;
    end
    return v[LEVEL_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] channel_of(input int unsigned pos);
    colour_t            col;
    logic [CHAN_W-1:0]  offs;
    int unsigned        full;
    col = colour_t'(pos % 3);
    case (col)
      COL_RED:   offs = CH_RED;
      COL_GREEN: offs = CH_GREEN;
      default:   offs = CH_BLUE;
    endcase
    full = (pos / 3) * 32'(CH_STEP) + 32'(offs);
    return full[CHAN_W-1:0];
  endfunction

  always @(posedge clk) begin
    channel_result_t want;
    channel_result_t got;
    if (!rst_n) begin
      due_q.delete();
      brightness = PCT_MAX;
      gamma_on   = 1'b1;
      framing    = 1'b0;
      byte_pos   = 0;
      failures   = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (!framing) begin
          if (in_mon.rx_byte == SYNC_BYTE) begin
            framing  = 1'b1;
            byte_pos = 0;
          end
        end else begin
          want.chan  = channel_of(byte_pos);
          want.level = graded_level(in_mon.rx_byte, brightness, gamma_on);
          want.last  = (byte_pos + 1 >= 3 * STRIPS);
          due_q.push_back(want);
          if (want.last) begin
            framing  = 1'b0;
            byte_pos = 0;
          end else begin
            byte_pos++;
          end
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.chan  = out_mon.channel_index;
        got.level = out_mon.drive_level;
        got.last  = out_mon.frame_end;
        if (due_q.size() == 0) begin
          $display("%0t: unexpected transfer chan %0d level %0d end %0b",
                   $realtime, got.chan, got.level, got.last);
          failures++;
        end else begin
          want = due_q.pop_front();
          if (got.chan !== want.chan) begin
            $display("%0t: channel_index expected %0d actual %0d",
                     $realtime, want.chan, got.chan);
            failures++;
          end
          if (got.level !== want.level) begin
            $display("%0t: drive_level expected %0d actual %0d",
                     $realtime, want.level, got.level);
            failures++;
          end
          if (got.last !== want.last) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $realtime, want.last, got.last);
            failures++;
          end
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_BRIGHTNESS) begin
          brightness = cfg_data;
        end else begin
          gamma_on = cfg_data[0];
        end
      end
    end
    pending = due_q.size();
  end

endmodule

// ===== tb/sv/tb_rgb_frame_gamma_dimmer.sv =====
module tb_rgb_frame_gamma_dimmer;
  timeunit 1ns;
  timeprecision 1ps;
  import rfgd_pkg::*;

  localparam int STRIPS    = 20;
  localparam int BYTE_GOAL = 1450;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic             cfg_index;
  logic [PCT_W-1:0] cfg_data;
  int               failures;
  int               pending;
  int               sent;
  int               burst_left;
  logic             steady;

  logic [BYTE_W-1:0] opening [16] = '{8'h00, 8'h7F, 8'hFE, SYNC_BYTE,
                                      8'h00, SYNC_BYTE, 8'h01, 8'hFE,
                                      8'h80, 8'h7F, 8'h0F, 8'hF0,
                                      8'h55, 8'hAA, SYNC_BYTE, 8'h00};

  rfgd_in_if  in_ch ();
  rfgd_out_if out_ch ();

  rgb_frame_gamma_dimmer #(.STRIPS(STRIPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  rfgd_frame_checker #(.STRIPS(STRIPS)) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_rgb_frame_gamma_dimmer failed");
    $finish;
  end

  // receiver stalls follow a pattern that is redrawn periodically from four random kinds
  initial begin
    logic [31:0] stall_pat;
    int          stall_tick;
    out_ch.ready = 1'b0;
    stall_pat    = '1;
    stall_tick   = 0;
    forever begin
      @(negedge clk);
      if (stall_tick % 48 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = $urandom;
          2: stall_pat = $urandom & $urandom;
          default: stall_pat = $urandom | $urandom;
        endcase
      end
      out_ch.ready <= stall_pat[stall_tick % 32];
      stall_tick++;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send(input logic [BYTE_W-1:0] b);
    if (burst_left == 0) begin
      if (!steady && $urandom_range(0, 9) > 2) begin
        pause_sender($urandom_range(1, 6));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push_byte(b);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_levels(input logic [PCT_W-1:0] pct, input logic gamma);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_BRIGHTNESS;
    cfg_data  <= pct;
    @(negedge clk);
    cfg_index <= REG_GAMMA;
    cfg_data  <= {6'($urandom), gamma};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_colour();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    if (r < 20) return 8'hFE;
    if (r < 24) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(input int target);
    int n;
    int r;
    int len;
    n = 0;
    while (n < target) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        len = $urandom_range(1, 4);
        repeat (len) send(8'($urandom_range(0, 254)));
      end else begin
        len = (r < 85) ? 3 * STRIPS : $urandom_range(1, 3 * STRIPS - 1);
        send(SYNC_BYTE);
        repeat (len) send(pick_colour());
      end
      n += len + 1;
    end
  endtask

  initial begin
    int phase;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_BRIGHTNESS;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    sent          = 0;
    burst_left    = 0;
    steady        = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset levels, dropped bytes, sync, extremes, sync value as data
    foreach (opening[i]) send(opening[i]);

    phase = 0;
    while (sent < BYTE_GOAL) begin
      settle();
      case (phase)
        0: set_levels(7'd0, 1'b1);
        1: set_levels(7'd0, 1'b0);
        2: set_levels(PCT_MAX, 1'b0);
        3: set_levels(7'd127, 1'b1);
        4: set_levels(7'd101, 1'b0);
        5: set_levels(7'd1, 1'b1);
        6: set_levels(7'd99, 1'b0);
        default: set_levels(7'($urandom_range(0, 127)), 1'($urandom));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(90, 140));
      phase++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (failures == 0) begin
      $display("tb_rgb_frame_gamma_dimmer passed");
    end else begin
      $display("tb_rgb_frame_gamma_dimmer failed");
    end
    $finish;
  end

endmodule

// ===== rgb_frame_gamma_dimmer.f =====
+incdir+hdl
hdl/rfgd_pkg.sv
hdl/rfgd_if.sv
hdl/rfgd_parser.sv
hdl/rfgd_queue.sv
hdl/rfgd_scaler.sv
hdl/rgb_frame_gamma_dimmer.sv
hdl/rfgd_checker.sv
tb/sv/rfgd_frame_checker.sv
tb/sv/tb_rgb_frame_gamma_dimmer.sv
